>>> hdl/lppe_pkg.sv
package lppe_pkg;

    localparam int COLOR_W  = 24;
    localparam int MODE_W   = 3;
    localparam int BRIGHT_W = 8;
    localparam int TIME_W   = 64;
    localparam int PRIO_W   = 2;
    localparam int FUNC_W   = 2;
    localparam int PER_W    = 21;

    localparam logic [FUNC_W-1:0] FUNC_SET       = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_COLOR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK      = 2'd2;

    localparam logic [MODE_W-1:0] PAT_DISABLED   = 3'd0;
    localparam logic [MODE_W-1:0] PAT_FADE_SLOW  = 3'd1;
    localparam logic [MODE_W-1:0] PAT_FADE_FAST  = 3'd2;
    localparam logic [MODE_W-1:0] PAT_FADE_ULTRA = 3'd3;
    localparam logic [MODE_W-1:0] PAT_BLINK_SLOW = 3'd4;
    localparam logic [MODE_W-1:0] PAT_BLINK_FAST = 3'd5;
    localparam logic [MODE_W-1:0] PAT_BLINK_ULTRA = 3'd6;
    localparam logic [MODE_W-1:0] PAT_SOLID      = 3'd7;

    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 8'hff;
    localparam logic [BRIGHT_W-1:0] BRIGHT_OFF  = 8'h00;

    typedef struct packed {
        logic                valid;
        logic [PRIO_W-1:0]   prio;
        logic [MODE_W-1:0]   mode;
        logic [COLOR_W-1:0]  rgb;
    } slot_wr_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [COLOR_W-1:0]  rgb;
    } active_t;

    // period in microseconds
    function automatic logic [PER_W-1:0] period_of(input logic [MODE_W-1:0] mode);
        logic [PER_W-1:0] per;
        unique case (mode)
            PAT_FADE_SLOW:   per = 21'd2000000;
            PAT_FADE_FAST:   per = 21'd1000000;
            PAT_FADE_ULTRA:  per = 21'd200000;
            PAT_BLINK_SLOW:  per = 21'd400000;
            PAT_BLINK_FAST:  per = 21'd200000;
            PAT_BLINK_ULTRA: per = 21'd100000;
            default:         per = 21'd1;
        endcase
        return per;
    endfunction

endpackage

>>> hdl/lppe_slots.sv
module lppe_slots #(
    parameter int SLOTS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lppe_pkg::slot_wr_t wr,
    output lppe_pkg::active_t  active
);
    import lppe_pkg::*;

    logic [MODE_W-1:0]  slot_mode_reg  [SLOTS];
    logic [COLOR_W-1:0] slot_rgb_reg   [SLOTS];
    logic [MODE_W-1:0]  slot_mode_next [SLOTS];
    logic [COLOR_W-1:0] slot_rgb_next  [SLOTS];
    active_t            active_reg;
    active_t            active_next;
    active_t            sel;
    logic               wr_hit;

    assign wr_hit = wr.valid && (int'(wr.prio) < SLOTS);

    always_comb
    begin
        sel = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_mode_next[i] = slot_mode_reg[i];
            slot_rgb_next[i]  = slot_rgb_reg[i];
            if (wr_hit && int'(wr.prio) == i)
            begin
                slot_mode_next[i] = wr.mode;
                slot_rgb_next[i]  = wr.rgb;
            end
        end
        // highest enabled slot wins
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_mode_next[i] != PAT_DISABLED)
            begin
                sel.mode = slot_mode_next[i];
                sel.rgb  = slot_rgb_next[i];
            end
        end
        active_next = wr_hit ? sel : active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_mode_reg[i] <= PAT_DISABLED;
                slot_rgb_reg[i]  <= '0;
            end
            active_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_mode_reg[i] <= slot_mode_next[i];
                slot_rgb_reg[i]  <= slot_rgb_next[i];
            end
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule

>>> hdl/lppe_bright.sv
module lppe_bright (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lppe_pkg::MODE_W-1:0]       mode,
    input  logic [lppe_pkg::TIME_W-1:0]       time_us,
    output logic                              done,
    output logic [lppe_pkg::BRIGHT_W-1:0]     brightness
);
    import lppe_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MOD,
        B_FOLD,
        B_DIV
    } bstate_t;

    localparam int REM_W = PER_W + BRIGHT_W;

    bstate_t             state_reg;
    logic [TIME_W-1:0]   t_reg;
    logic [PER_W-1:0]    per_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-2:0]    d_reg;
    logic [5:0]          cnt_reg;
    logic                odd_reg;
    logic                fade_reg;
    logic [BRIGHT_W-1:0] q_reg;
    logic                done_reg;
    logic [BRIGHT_W-1:0] bright_reg;

    logic [PER_W:0]      mod_shift;
    logic                mod_ge;
    logic [PER_W:0]      pos;
    logic [REM_W:0]      num;
    logic                div_ge;

    always_comb
    begin
        mod_shift = {rem_reg[PER_W-1:0], t_reg[TIME_W-1]};
        mod_ge    = mod_shift >= {1'b0, per_reg};
        pos       = odd_reg ? ({1'b0, per_reg} - {1'b0, rem_reg[PER_W-1:0]})
                            : {1'b0, rem_reg[PER_W-1:0]};
        num       = {pos, 8'b0} - {8'b0, pos};
        div_ge    = rem_reg >= {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            t_reg      <= '0;
            per_reg    <= '0;
            rem_reg    <= '0;
            d_reg      <= '0;
            cnt_reg    <= '0;
            odd_reg    <= 1'b0;
            fade_reg   <= 1'b0;
            q_reg      <= '0;
            done_reg   <= 1'b0;
            bright_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (start)
                    begin
                        t_reg    <= time_us;
                        per_reg  <= period_of(mode);
                        rem_reg  <= '0;
                        cnt_reg  <= '0;
                        odd_reg  <= 1'b0;
                        fade_reg <= (mode <= PAT_FADE_ULTRA);
                        if (mode == PAT_DISABLED)
                        begin
                            bright_reg <= BRIGHT_OFF;
                            done_reg   <= 1'b1;
                        end
                        else if (mode == PAT_SOLID)
                        begin
                            bright_reg <= BRIGHT_FULL;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= B_MOD;
                        end
                    end
                end
                // one time bit per cycle, MSB first
                B_MOD:
                begin
                    t_reg   <= {t_reg[TIME_W-2:0], 1'b0};
                    odd_reg <= mod_ge;
                    rem_reg <= REM_W'(mod_ge ? (mod_shift - {1'b0, per_reg}) : mod_shift);
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        state_reg <= B_FOLD;
                    end
                end
                B_FOLD:
                begin
                    if (fade_reg)
                    begin
                        rem_reg   <= REM_W'(num);
                        d_reg     <= {per_reg, 7'b0};
                        cnt_reg   <= '0;
                        q_reg     <= '0;
                        state_reg <= B_DIV;
                    end
                    else
                    begin
                        bright_reg <= ({pos, 1'b0} >= {2'b0, per_reg}) ? BRIGHT_FULL
                                                                       : BRIGHT_OFF;
                        done_reg   <= 1'b1;
                        state_reg  <= B_IDLE;
                    end
                end
                B_DIV:
                begin
                    if (div_ge)
                    begin
                        rem_reg <= rem_reg - {1'b0, d_reg};
                    end
                    q_reg   <= {q_reg[BRIGHT_W-2:0], div_ge};
                    d_reg   <= {1'b0, d_reg[REM_W-2:1]};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        bright_reg <= {q_reg[BRIGHT_W-2:0], div_ge};
                        done_reg   <= 1'b1;
                        state_reg  <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign brightness = bright_reg;

endmodule

>>> hdl/led_priority_pattern_engine_unit.sv
// LED priority pattern engine.
// Input stream (s_*): one word per item, func in s_tuser. Set and set-colour
// words update the slot file in the cycle they are taken and give no output.
// A tick word yields one output word on the m_* stream: active colour,
// brightness and active pattern.
// Solid or disabled ticks get their brightness directly on acceptance; else the
// time field is reduced by its period one bit per cycle, a fold step mirrors
// odd periods, and for fade the ramp then runs through a serial divider for an
// 8-bit quotient. The output register loads once the brightness is done and
// the output register is free. s_tready is low while a tick is in the
// brightness unit and comes back with m_tvalid, so one tick is handled at a
// time; set words are taken every cycle while no tick is in progress.
// The output word sits in a register: a new tick is accepted while the
// previous word still waits. If the receiver stalls when a result is ready,
// the block holds it and keeps s_tready low until the output register frees.
// Reset clears all slots to disabled black, the active pattern to disabled
// and drops m_tvalid.
module led_priority_pattern_engine_unit #(
    parameter int SLOTS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // priority_req[1:0], pattern[4:2], color[28:5], time_us[92:29]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // out_color[23:0], brightness[31:24], active_mode[34:32]
);
    import lppe_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,
        T_BUSY,
        T_HOLD
    } tstate_t;

    tstate_t             state_reg;
    logic                m_tvalid_reg;
    logic [COLOR_W-1:0]  out_color_reg;
    logic [BRIGHT_W-1:0] out_bright_reg;
    logic [MODE_W-1:0]   out_mode_reg;
    active_t             pend_reg;

    logic                accept;
    logic                start;
    logic                out_free;
    logic                load;
    slot_wr_t            wr;
    active_t             active;
    logic                b_done;
    logic [BRIGHT_W-1:0] b_bright;

    assign accept   = s_tvalid && s_tready;
    assign start    = accept && (s_tuser == FUNC_TICK);
    assign out_free = !m_tvalid_reg || m_tready;
    assign load     = out_free && ((state_reg == T_BUSY && b_done) || state_reg == T_HOLD);

    always_comb
    begin
        wr.valid = accept && (s_tuser == FUNC_SET || s_tuser == FUNC_SET_COLOR);
        wr.prio  = s_tdata[1:0];
        wr.mode  = (s_tuser == FUNC_SET) ? s_tdata[4:2] : active.mode;
        wr.rgb   = s_tdata[28:5];
    end

    lppe_slots #(
        .SLOTS (SLOTS)
    ) u_slots (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .active (active)
    );

    lppe_bright u_bright (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (active.mode),
        .time_us    (s_tdata[92:29]),
        .done       (b_done),
        .brightness (b_bright)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            m_tvalid_reg   <= 1'b0;
            out_color_reg  <= '0;
            out_bright_reg <= '0;
            out_mode_reg   <= PAT_DISABLED;
            pend_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                m_tvalid_reg   <= 1'b1;
                out_color_reg  <= pend_reg.rgb;
                out_bright_reg <= b_bright;
                out_mode_reg   <= pend_reg.mode;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        pend_reg  <= active;
                        state_reg <= T_BUSY;
                    end
                end
                T_BUSY:
                begin
                    if (b_done)
                    begin
                        state_reg <= load ? T_IDLE : T_HOLD;
                    end
                end
                T_HOLD:
                begin
                    if (load)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == T_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_mode_reg, out_bright_reg, out_color_reg};

endmodule

>>> hdl/lppe_chk.sv
module lppe_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    import lppe_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == FUNC_TICK |=> !s_tready)
        else $error("tick did not occupy the engine");

    a_set_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != FUNC_TICK |=> s_tready)
        else $error("set word stalled input");

    a_disabled_dark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34:32] == PAT_DISABLED |->
            m_tdata[31:24] == BRIGHT_OFF && m_tdata[23:0] == 24'd0)
        else $error("disabled pattern not dark");

    a_solid_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34:32] == PAT_SOLID |-> m_tdata[31:24] == BRIGHT_FULL)
        else $error("solid pattern not full on");

endmodule

bind led_priority_pattern_engine_unit lppe_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/led_priority_pattern_engine_unit_test.sv
module led_priority_pattern_engine_unit_test;

    import lppe_pkg::*;

    localparam int SLOT_COUNT     = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 1030;
    localparam int SETTLE_CYCLES  = 100;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [BRIGHT_W-1:0] level;
        logic [COLOR_W-1:0]  rgb;
    } light_t;

    function automatic logic [63:0] mode_period(input logic [MODE_W-1:0] mode);
        case (mode)
            PAT_FADE_SLOW:   return 64'd2000000;
            PAT_FADE_FAST:   return 64'd1000000;
            PAT_FADE_ULTRA:  return 64'd200000;
            PAT_BLINK_SLOW:  return 64'd400000;
            PAT_BLINK_FAST:  return 64'd200000;
            PAT_BLINK_ULTRA: return 64'd100000;
            default:         return 64'd0;
        endcase
    endfunction

    class light_scoreboard;
        logic [MODE_W-1:0]  slot_mode [SLOT_COUNT];
        logic [COLOR_W-1:0] slot_rgb [SLOT_COUNT];
        logic [MODE_W-1:0]  active_mode;
        logic [COLOR_W-1:0] active_rgb;
        light_t             pending_lights [$];
        int                 errors;
        int                 checked;
        int                 writes;
        int                 ticks;
        int                 ignored;

        function new();
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_mode[i] = PAT_DISABLED;
                slot_rgb[i]  = '0;
            end
            active_mode = PAT_DISABLED;
            active_rgb  = '0;
            errors      = 0;
            checked     = 0;
            writes      = 0;
            ticks       = 0;
            ignored     = 0;
        endfunction

        function void write_slot(input logic [PRIO_W-1:0] prio, input logic [MODE_W-1:0] mode,
                                 input logic [COLOR_W-1:0] rgb);
            if (prio >= SLOT_COUNT)
                return;
            slot_mode[prio] = mode;
            slot_rgb[prio]  = rgb;
            writes++;
            for (int p = SLOT_COUNT - 1; p >= 0; p--)
            begin
                if (slot_mode[p] != PAT_DISABLED)
                begin
                    active_mode = slot_mode[p];
                    active_rgb  = slot_rgb[p];
                    return;
                end
            end
            active_mode = PAT_DISABLED;
            active_rgb  = '0;
        endfunction

        function void note_word(input logic [FUNC_W-1:0] func, input logic [PRIO_W-1:0] prio,
                                input logic [MODE_W-1:0] pat, input logic [COLOR_W-1:0] rgb,
                                input logic [TIME_W-1:0] t);
            logic [63:0] per;
            logic [63:0] pos;
            logic [63:0] turns;
            light_t      light;
            case (func)
                FUNC_SET:       write_slot(prio, pat, rgb);
                FUNC_SET_COLOR: write_slot(prio, active_mode, rgb);
                FUNC_TICK:
                begin
                    per = mode_period(active_mode);
                    light.mode = active_mode;
                    light.rgb  = active_rgb;
                    if (active_mode == PAT_SOLID)
                        light.level = BRIGHT_FULL;
                    else if (per == 0)
                        light.level = BRIGHT_OFF;
                    else
                    begin
                        pos   = t % per;
                        turns = t / per;
                        if (turns[0])
                            pos = per - pos;
                        if (active_mode <= PAT_FADE_ULTRA)
                            light.level = BRIGHT_W'((pos * 255) / per);
                        else
                            light.level = (2 * pos >= per) ? BRIGHT_FULL : BRIGHT_OFF;
                    end
                    pending_lights.push_back(light);
                    ticks++;
                end
                default: ignored++;
            endcase
        endfunction

        task report_mismatch(input string what, input logic [39:0] want, input logic [39:0] got);
            $display("mismatch %s: expected %0h got %0h", what, want, got);
            errors++;
        endtask

        task check_light(input logic [39:0] word);
            light_t want;
            if (pending_lights.size() == 0)
            begin
                report_mismatch("unexpected output word", '0, word);
                return;
            end
            want = pending_lights.pop_front();
            checked++;
            if (word[23:0] != want.rgb)
                report_mismatch("out_color", 40'(want.rgb), 40'(word[23:0]));
            if (word[31:24] != want.level)
                report_mismatch("brightness", 40'(want.level), 40'(word[31:24]));
            if (word[34:32] != want.mode)
                report_mismatch("active_mode", 40'(want.mode), 40'(word[34:32]));
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    light_scoreboard sb = new();

    led_priority_pattern_engine_unit #(
        .SLOTS(SLOT_COUNT)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            repeat ($urandom_range(100, 400)) @(negedge clk);
            tx_burst = ($urandom_range(0, 2) == 0);
            rx_burst = ($urandom_range(0, 2) == 0);
        end
    end

    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [PRIO_W-1:0] prio,
                             input logic [MODE_W-1:0] pat, input logic [COLOR_W-1:0] rgb,
                             input logic [TIME_W-1:0] t);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t, rgb, pat, prio};
        s_tuser  <= func;
        do @(posedge clk); while (!s_tready);
        sb.note_word(func, prio, pat, rgb, t);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_lights.size() != 0)
            @(posedge clk);
    endtask

    // receiver
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sb.checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = rx_burst ? 0 : $urandom_range(0, 9);
            repeat (gap)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_light(m_tdata);
        end
    end

    // watchdog: cycles without any word moving
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
        $display("led_priority_pattern_engine_unit regression: fail");
        $finish;
    end

    // stimulus
    initial
    begin
        int                 counted;
        int                 pick;
        logic [FUNC_W-1:0]  func;
        logic [MODE_W-1:0]  pat;
        logic [COLOR_W-1:0] rgb;
        logic [TIME_W-1:0]  t;
        logic [63:0]        per;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(FUNC_TICK, 2'd0, PAT_DISABLED, 24'h000000, '0);
        send_word(FUNC_TICK, 2'd3, PAT_SOLID, 24'hffffff, '1);
        send_word(FUNC_SET, 2'd0, PAT_FADE_SLOW, 24'hffffff, '0);
        send_word(FUNC_TICK, 2'd0, PAT_DISABLED, 24'h000000, 64'd0);
        send_word(FUNC_TICK, 2'd0, PAT_DISABLED, 24'h000000, 64'd1999999);
        send_word(FUNC_TICK, 2'd0, PAT_DISABLED, 24'h000000, 64'd2000000);
        send_word(FUNC_TICK, 2'd0, PAT_DISABLED, 24'h000000, 64'd3000000);
        send_word(FUNC_TICK, 2'd0, PAT_DISABLED, 24'h000000, '1);
        send_word(FUNC_SET, 2'd3, PAT_BLINK_ULTRA, 24'h000000, '1);
        send_word(FUNC_TICK, 2'd1, PAT_SOLID, 24'h000000, 64'd49999);
        send_word(FUNC_TICK, 2'd1, PAT_SOLID, 24'h000000, 64'd50000);
        send_word(FUNC_TICK, 2'd1, PAT_SOLID, 24'h000000, 64'd150000);
        // slot 2 takes the active blink pattern
        send_word(FUNC_SET_COLOR, 2'd2, PAT_DISABLED, 24'habcdef, '0);
        send_word(FUNC_SET, 2'd3, PAT_SOLID, 24'h123456, '0);
        send_word(FUNC_TICK, 2'd0, PAT_DISABLED, 24'h000000, 64'd12345);
        send_word(FUNC_SET, 2'd3, PAT_DISABLED, 24'h000000, '0);
        send_word(FUNC_TICK, 2'd0, PAT_DISABLED, 24'h000000, 64'd75000);
        // every slot off: disabled black
        send_word(FUNC_SET, 2'd2, PAT_DISABLED, 24'h000000, '0);
        send_word(FUNC_SET, 2'd0, PAT_DISABLED, 24'h000000, '0);
        send_word(FUNC_TICK, 2'd0, PAT_DISABLED, 24'h000000, 64'd500000);
        send_word(FUNC_UNUSED, 2'd1, PAT_SOLID, 24'h555555, '1);
        send_word(FUNC_SET_COLOR, 2'd1, PAT_SOLID, 24'hffffff, '0);
        send_word(FUNC_TICK, 2'd3, PAT_SOLID, 24'hffffff, '1);
        wait_drained();

        for (int half = 0; half < 2; half++)
        begin
            counted = 0;
            while (counted < RANDOM_WORDS / 2)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    func = FUNC_SET;
                else if (pick < 45)
                    func = FUNC_SET_COLOR;
                else if (pick < 95)
                    func = FUNC_TICK;
                else
                    func = FUNC_UNUSED;
                pat = MODE_W'($urandom_range(0, 7));
                case ($urandom_range(0, 5))
                    0:       rgb = '0;
                    1:       rgb = '1;
                    default: rgb = COLOR_W'($urandom);
                endcase
                per = mode_period(sb.active_mode);
                if (per == 0)
                    per = mode_period(PAT_FADE_SLOW);
                case ($urandom_range(0, 4))
                    0: t = {$urandom, $urandom};
                    1: t = 64'($urandom_range(0, 5000000));
                    2: t = per * $urandom_range(0, 1000) + $urandom_range(0, 4) - 2;
                    3: t = per * $urandom_range(0, 1000) + per / 2 + $urandom_range(0, 4) - 2;
                    default: t = {32'hffffffff, $urandom};
                endcase
                send_word(func, PRIO_W'($urandom_range(0, 3)), pat, rgb, t);
                counted++;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d slot writes, %0d ticks, %0d ignored words", sb.writes, sb.ticks,
                 sb.ignored);
        $display("checked %0d output words across all patterns and idle/stall mixes", sb.checked);
        if (sb.errors == 0)
            $display("led_priority_pattern_engine_unit regression: pass");
        else
            $display("led_priority_pattern_engine_unit regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
hdl/lppe_pkg.sv
hdl/lppe_slots.sv
hdl/lppe_bright.sv
hdl/led_priority_pattern_engine_unit.sv
hdl/lppe_chk.sv
tb/led_priority_pattern_engine_unit_test.sv
